// ===== hdl/cts_pkg.sv =====
package cts_pkg;

   localparam int CTS_MAX_TERMS = 20;
   localparam int CTS_FRAC_BITS = 29;

   localparam int ANGLE_W   = 32;
   localparam int TOL_W     = 30;
   localparam int TERMS_W   = 5;
   localparam int TERM_W    = 62;
   localparam int CHUNK_W   = 16;
   localparam int DIV_STEPS = 8;

   localparam logic [TOL_W-1:0]  TOL_RESET = 30'd5368709;
   localparam logic [TERM_W-1:0] TERM_CAP  = 62'h2000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQ_STORE,
      ST_ACCUM,
      ST_MULT,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/cosine_taylor_series.sv =====
// Start is taken again in the strobe cycle; no new angle is accepted while busy.
// Each term costs one accumulate; each term but the last also costs three 62x16 multiply passes and a divide.
// Synchronous active-high reset idles the sequencer and restores the tolerance register.
// The receiver cannot stall: the strobe lasts exactly one cycle.
module cosine_taylor_series import cts_pkg::*; #(
   parameter int MAX_TERMS = CTS_MAX_TERMS,
   parameter int FRAC_BITS = CTS_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      busy,
   input  logic                      csr_write_en,
   input  logic [TOL_W-1:0]          csr_write_data,
   output logic                      rsp_strobe,
   output logic signed [ANGLE_W-1:0] rsp_cosine,
   output logic [TERMS_W-1:0]        rsp_terms_used,
   output logic                      rsp_limit_hit
);

   localparam int SQ_W    = 2 * ANGLE_W - 1 - FRAC_BITS;
   localparam int NCH     = (SQ_W + CHUNK_W - 1) / CHUNK_W;
   localparam int B_W     = NCH * CHUNK_W;
   localparam int P_W     = TERM_W + B_W;
   localparam int PP_W    = TERM_W + CHUNK_W;
   localparam int N_W     = $clog2(MAX_TERMS);
   localparam int MCNT_W  = $clog2(NCH + 1);
   localparam int DIV_MAX = (2 * MAX_TERMS - 1) * (2 * MAX_TERMS);
   localparam int D_W     = $clog2(DIV_MAX + 1);
   localparam int ACC_W   = TERM_W + 1;
   localparam int SUM_W   = TERM_W + 2;

   localparam logic signed [SUM_W-1:0] ACC_LIM  = $signed({2'b00, TERM_CAP});
   localparam logic signed [SUM_W-1:0] ACC_NLIM = -ACC_LIM;
   localparam logic signed [ACC_W-1:0] OUT_HI   = 63'sh0000_0000_7fff_ffff;
   localparam logic signed [ACC_W-1:0] OUT_LO   = 63'sh7fff_ffff_8000_0000;

   state_type state_ff, state_in;

   logic [MCNT_W-1:0]       mcnt_ff;
   logic [TOL_W-1:0]        tol_ff;
   logic                    rsp_strobe_ff;
   logic [TERM_W-1:0]       mul_a_ff;
   logic [B_W-1:0]          mul_b_ff;
   logic [P_W-1:0]          prod_ff, prod_in;
   logic [SQ_W-1:0]         sq_ff;
   logic [TERM_W-1:0]       term_ff;
   logic [N_W-1:0]          n_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ANGLE_W-1:0] rsp_cosine_ff, cos_sat;
   logic [TERMS_W-1:0]      rsp_terms_ff;
   logic                    rsp_limit_ff;

   logic [ANGLE_W-1:0]      mag;
   logic [CHUNK_W-1:0]      chunk;
   logic [PP_W-1:0]         pp;
   logic [P_W-1:0]          shifted;
   logic [TERM_W-1:0]       sat_val;
   logic [N_W:0]            odd_f, used;
   logic [N_W+1:0]          even_f;
   logic [2*N_W+2:0]        dprod;
   logic [D_W-1:0]          divisor;
   logic signed [SUM_W-1:0] acc_ext, term_s, sum;
   logic                    term_small, stop_now;
   logic                    div_last;
   logic [TERM_W-1:0]       div_quotient;

   logic mul_load_sq, mul_load_term, mul_run, sq_store, acc_step;
   logic div_load, term_store, rsp_load;

   assign mag        = req_angle[ANGLE_W-1] ? (~req_angle + 1'b1) : req_angle;
   assign term_small = (term_ff < TERM_W'(tol_ff));
   assign stop_now   = term_small || (n_ff == N_W'(MAX_TERMS - 1));

   assign chunk   = mul_b_ff[B_W-1 -: CHUNK_W];
   assign pp      = mul_a_ff * chunk;
   assign prod_in = (prod_ff << CHUNK_W) + P_W'(pp);
   assign shifted = prod_ff >> FRAC_BITS;
   assign sat_val = (shifted > P_W'(TERM_CAP)) ? TERM_CAP : shifted[TERM_W-1:0];

   assign odd_f   = {n_ff, 1'b1};
   assign even_f  = {({1'b0, n_ff} + 1'b1), 1'b0};
   assign dprod   = odd_f * even_f;
   assign divisor = D_W'(dprod);
   assign used    = {1'b0, n_ff} + 1'b1;

   assign acc_ext = {acc_ff[ACC_W-1], acc_ff};
   assign term_s  = $signed({2'b00, term_ff});
   assign sum     = n_ff[0] ? (acc_ext - term_s) : (acc_ext + term_s);

   always_comb begin
      if (sum > ACC_LIM) begin
         acc_in = ACC_W'(ACC_LIM);
      end else if (sum < ACC_NLIM) begin
         acc_in = ACC_W'(ACC_NLIM);
      end else begin
         acc_in = ACC_W'(sum);
      end
   end

   always_comb begin
      if (acc_ff > OUT_HI) begin
         cos_sat = ANGLE_W'(OUT_HI);
      end else if (acc_ff < OUT_LO) begin
         cos_sat = ANGLE_W'(OUT_LO);
      end else begin
         cos_sat = acc_ff[ANGLE_W-1:0];
      end
   end

   cts_divider #(
      .DIVISOR_W (D_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (sat_val),
      .divisor  (divisor),
      .last     (div_last),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start) state_in = ST_SQUARE;
         ST_SQUARE:   if (mcnt_ff == MCNT_W'(1)) state_in = ST_SQ_STORE;
         ST_SQ_STORE: state_in = ST_ACCUM;
         ST_ACCUM:    state_in = stop_now ? ST_FINISH : ST_MULT;
         ST_MULT:     if (mcnt_ff == MCNT_W'(1)) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIVIDE;
         ST_DIVIDE:   if (div_last) state_in = ST_ACCUM;
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_load_sq   = 1'b0;
      mul_load_term = 1'b0;
      mul_run       = 1'b0;
      sq_store      = 1'b0;
      acc_step      = 1'b0;
      div_load      = 1'b0;
      term_store    = 1'b0;
      rsp_load      = 1'b0;
      busy          = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            mul_load_sq = start;
         end
         ST_SQUARE:   mul_run = 1'b1;
         ST_SQ_STORE: sq_store = 1'b1;
         ST_ACCUM: begin
            acc_step      = 1'b1;
            mul_load_term = !stop_now;
         end
         ST_MULT:     mul_run = 1'b1;
         ST_DIV_LOAD: div_load = 1'b1;
         ST_DIVIDE:   term_store = div_last;
         ST_FINISH:   rsp_load = 1'b1;
         default:     busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mcnt_ff       <= '0;
         tol_ff        <= TOL_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_load;
         if (csr_write_en) begin
            tol_ff <= csr_write_data;
         end
         if (mul_load_sq || mul_load_term) begin
            mcnt_ff <= MCNT_W'(NCH);
         end else if (mul_run) begin
            mcnt_ff <= mcnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load_sq) begin
         mul_a_ff <= TERM_W'(mag);
         mul_b_ff <= B_W'(mag);
         prod_ff  <= '0;
      end else if (mul_load_term) begin
         mul_a_ff <= term_ff;
         mul_b_ff <= B_W'(sq_ff);
         prod_ff  <= '0;
      end else if (mul_run) begin
         mul_b_ff <= mul_b_ff << CHUNK_W;
         prod_ff  <= prod_in;
      end
      if (sq_store) begin
         sq_ff   <= SQ_W'(sat_val);
         term_ff <= TERM_W'(1) << FRAC_BITS;
         n_ff    <= '0;
         acc_ff  <= '0;
      end else begin
         if (acc_step) begin
            acc_ff <= acc_in;
         end
         if (term_store) begin
            term_ff <= div_quotient;
            n_ff    <= n_ff + 1'b1;
         end
      end
      if (rsp_load) begin
         rsp_cosine_ff <= cos_sat;
         rsp_terms_ff  <= TERMS_W'(used);
         rsp_limit_ff  <= !term_small;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cosine     = rsp_cosine_ff;
   assign rsp_terms_used = rsp_terms_ff;
   assign rsp_limit_hit  = rsp_limit_ff;

endmodule

// ===== hdl/cts_divider.sv =====
module cts_divider import cts_pkg::*; #(
   parameter int DIVISOR_W = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [TERM_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 last,
   output logic [TERM_W-1:0]    quotient
);

   localparam int DIV_CYC = (TERM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W   = DIV_CYC * DIV_STEPS;
   localparam int CNT_W   = $clog2(DIV_CYC + 1);

   logic [DIV_W-1:0]     shift_ff, shift_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [CNT_W-1:0]     cnt_ff;

   always_comb begin
      logic [DIVISOR_W:0]   trial;
      logic [DIV_W-1:0]     sh;
      logic [DIVISOR_W-1:0] rm;
      sh = shift_ff;
      rm = rem_ff;
      trial = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {rm, sh[DIV_W-1]};
         if (trial >= {1'b0, dvs_ff}) begin
            rm = DIVISOR_W'(trial - {1'b0, dvs_ff});
            sh = {sh[DIV_W-2:0], 1'b1};
         end else begin
            rm = trial[DIVISOR_W-1:0];
            sh = {sh[DIV_W-2:0], 1'b0};
         end
      end
      shift_in = sh;
      rem_in   = rm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= CNT_W'(DIV_CYC);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff <= DIV_W'(dividend);
         rem_ff   <= '0;
         dvs_ff   <= divisor;
      end else if (cnt_ff != '0) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
      end
   end

   assign last     = (cnt_ff == CNT_W'(1));
   assign quotient = shift_in[TERM_W-1:0];

endmodule

// ===== hdl/cts_checker.sv =====
module cts_checker import cts_pkg::*; #(
   parameter int MAX_TERMS = CTS_MAX_TERMS
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [TERMS_W-1:0] rsp_terms_used,
   input logic               rsp_limit_hit
);

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted transaction did not raise busy");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_limit_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_limit_hit |-> rsp_terms_used == TERMS_W'(MAX_TERMS))
      else $error("term limit flagged with wrong term count");

endmodule

bind cosine_taylor_series cts_checker #(
   .MAX_TERMS (MAX_TERMS)
) u_cts_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_terms_used (rsp_terms_used),
   .rsp_limit_hit  (rsp_limit_hit)
);
